>>> hw/rtl/swq_pkg.sv
package swq_pkg;

   localparam int DEPTH = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_MOVE   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_FIND,
      S_DROP,
      S_SCAN,
      S_PLACE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [63:0] peer_key;
      logic [31:0] backoff_time;
      logic [7:0]  initial_count;
      logic        bump_count;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [4:0]  occupancy;
      logic        head_valid;
      logic [63:0] head_key;
      logic [31:0] head_time;
      logic [7:0]  head_count;
      logic [7:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       idx_clr;
      logic       idx_inc;
      logic       capture;
      logic       drop;
      logic       place;
      logic       rsp_load;
      status_type status;
   } dp_cmd_type;

   typedef struct packed {
      logic       at_end;
      logic       key_hit;
      logic       time_ge;
      logic       full;
      logic [1:0] command;
   } dp_stat_type;

endpackage

>>> hw/rtl/swq_ctrl.sv
module swq_ctrl import swq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   state_type  state_ff, state_in;
   status_type status_ff, status_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = ST_DONE;
            unique case (dp_stat.command)
               CMD_INSERT: begin
                  if (dp_stat.full) begin
                     status_in = ST_FULL;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               CMD_REMOVE, CMD_MOVE: state_in = S_FIND;
               default: state_in = S_FINISH;
            endcase
         end
         S_FIND: begin
            if (dp_stat.at_end) begin
               status_in = ST_NOT_FOUND;
               state_in = S_FINISH;
            end else if (dp_stat.key_hit) begin
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            state_in = (dp_stat.command == CMD_MOVE) ? S_SCAN : S_FINISH;
         end
         S_SCAN: begin
            if (dp_stat.at_end || dp_stat.time_ge) begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: state_in = S_FINISH;
         S_FINISH: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd = '0;
      dp_cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            dp_cmd.load = req_valid;
            dp_cmd.idx_clr = req_valid;
         end
         S_FIND: begin
            dp_cmd.idx_inc = !dp_stat.at_end && !dp_stat.key_hit;
            dp_cmd.capture = !dp_stat.at_end && dp_stat.key_hit;
         end
         S_DROP: begin
            dp_cmd.drop = 1'b1;
            dp_cmd.idx_clr = 1'b1;
         end
         S_SCAN: dp_cmd.idx_inc = !(dp_stat.at_end || dp_stat.time_ge);
         S_PLACE: dp_cmd.place = 1'b1;
         S_FINISH: dp_cmd.rsp_load = slot_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         status_ff <= ST_DONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.rsp_load |-> slot_free)
      else $error("result loaded over a pending beat");
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_DISPATCH))
      else $error("accepted beat not dispatched");
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && slot_free) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("finish did not present a result");

endmodule

>>> hw/rtl/swq_datapath.sv
module swq_datapath import swq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat,
   output rsp_type     rsp_data
);

   req_type            req_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   fill_ff, fill_in;
   logic [7:0]         count_ff, count_in;
   logic [63:0]        keys_ff [DEPTH];
   logic [63:0]        keys_in [DEPTH];
   logic [31:0]        times_ff [DEPTH];
   logic [31:0]        times_in [DEPTH];
   logic [7:0]         counts_ff [DEPTH];
   logic [7:0]         counts_in [DEPTH];
   rsp_type            rsp_ff;
   logic [ADDR_W-1:0]  addr;
   logic [7:0]         cur_count;

   assign addr = idx_ff[ADDR_W-1:0];
   assign cur_count = counts_ff[addr];

   assign dp_stat.at_end = (idx_ff == fill_ff);
   assign dp_stat.key_hit = (keys_ff[addr] == req_ff.peer_key);
   assign dp_stat.time_ge = (times_ff[addr] >= req_ff.backoff_time);
   assign dp_stat.full = (fill_ff == IDX_W'(DEPTH));
   assign dp_stat.command = req_ff.command;
   assign rsp_data = rsp_ff;

   always_comb begin
      idx_in = idx_ff;
      if (dp_cmd.idx_clr) begin
         idx_in = '0;
      end else if (dp_cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (dp_cmd.drop) begin
         fill_in = fill_ff - 1'b1;
      end else if (dp_cmd.place) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (dp_cmd.load) begin
         count_in = req_data.initial_count;
      end else if (dp_cmd.capture) begin
         count_in = (req_ff.bump_count && (cur_count != 8'hFF)) ? cur_count + 8'd1 : cur_count;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         keys_in[i] = keys_ff[i];
         times_in[i] = times_ff[i];
         counts_in[i] = counts_ff[i];
      end
      if (dp_cmd.drop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (IDX_W'(i) >= idx_ff) begin
               keys_in[i] = keys_ff[i + 1];
               times_in[i] = times_ff[i + 1];
               counts_in[i] = counts_ff[i + 1];
            end
         end
      end else if (dp_cmd.place) begin
         for (int i = 1; i < DEPTH; i++) begin
            if (IDX_W'(i) > idx_ff) begin
               keys_in[i] = keys_ff[i - 1];
               times_in[i] = times_ff[i - 1];
               counts_in[i] = counts_ff[i - 1];
            end
         end
         keys_in[addr] = req_ff.peer_key;
         times_in[addr] = req_ff.backoff_time;
         counts_in[addr] = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         fill_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         req_ff <= req_data;
      end
      count_ff <= count_in;
      for (int i = 0; i < DEPTH; i++) begin
         keys_ff[i] <= keys_in[i];
         times_ff[i] <= times_in[i];
         counts_ff[i] <= counts_in[i];
      end
      if (dp_cmd.rsp_load) begin
         rsp_ff.status <= dp_cmd.status;
         rsp_ff.occupancy <= 5'(fill_ff);
         rsp_ff.head_valid <= (fill_ff != '0);
         rsp_ff.head_key <= (fill_ff != '0) ? keys_ff[0] : 64'd0;
         rsp_ff.head_time <= (fill_ff != '0) ? times_ff[0] : 32'd0;
         rsp_ff.head_count <= (fill_ff != '0) ? counts_ff[0] : 8'd0;
         rsp_ff.entry_count <= ((req_ff.command == CMD_MOVE) && (dp_cmd.status == ST_DONE))
                               ? count_ff : 8'd0;
      end
   end

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= IDX_W'(DEPTH))
      else $error("fill level beyond depth");
   a_place_room: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.place |-> (fill_ff < IDX_W'(DEPTH)) && (idx_ff <= fill_ff))
      else $error("place without room");
   a_drop_held: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.drop |-> (idx_ff < fill_ff))
      else $error("drop outside held entries");

endmodule

>>> hw/rtl/sorted_wait_queue.sv
// channel  | ports                      | beat
// request  | req_valid/req_ready/req_data | command, key, wait time, counts
// response | rsp_valid/rsp_ready/rsp_data | status, occupancy, head, moved count
//
// One command at a time: a key search walks one entry per cycle, a time scan walks
// one entry per cycle, and each shift moves all the entries behind the slot at once.
// Steps: insert is dispatch, scan, place, finish; remove is dispatch, find, drop,
// finish; move is dispatch, find, drop, scan, place, finish.
// Reset clears the fill level and handshake state; entry contents stay undefined.
// A finished result waits in the output register while the next request is accepted;
// the block holds in its finish state while that register is still full.
module sorted_wait_queue import swq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   swq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   swq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .dp_cmd   (dp_cmd),
      .dp_stat  (dp_stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> bench/testbench.sv
module testbench import swq_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 64;
   localparam int MAX_REPORTS = 10;
   localparam int RANDOM_ITEMS = 750;

   class queue_mirror;
      logic [63:0] keys[DEPTH];
      logic [31:0] times[DEPTH];
      logic [7:0]  counts[DEPTH];
      int fill;
      rsp_type awaited[$];
      int mismatches;

      function int find_key(logic [63:0] key);
         for (int i = 0; i < fill; i++) begin
            if (keys[i] == key) return i;
         end
         return -1;
      endfunction

      function void drop_at(int pos);
         for (int i = pos; i + 1 < fill; i++) begin
            keys[i] = keys[i + 1];
            times[i] = times[i + 1];
            counts[i] = counts[i + 1];
         end
         fill--;
      endfunction

      function void place(logic [63:0] key, logic [31:0] wt, logic [7:0] cnt);
         int pos;
         pos = 0;
         while (pos < fill && times[pos] < wt) pos++;
         for (int i = fill; i > pos; i--) begin
            keys[i] = keys[i - 1];
            times[i] = times[i - 1];
            counts[i] = counts[i - 1];
         end
         keys[pos] = key;
         times[pos] = wt;
         counts[pos] = cnt;
         fill++;
      endfunction

      function void apply_command(req_type r);
         rsp_type e;
         int pos;
         logic [7:0] cnt;
         e = '0;
         case (r.command)
            CMD_INSERT: begin
               if (fill >= DEPTH) e.status = ST_FULL;
               else place(r.peer_key, r.backoff_time, r.initial_count);
            end
            CMD_REMOVE: begin
               pos = find_key(r.peer_key);
               if (pos < 0) e.status = ST_NOT_FOUND;
               else drop_at(pos);
            end
            CMD_MOVE: begin
               pos = find_key(r.peer_key);
               if (pos < 0) begin
                  e.status = ST_NOT_FOUND;
               end else begin
                  cnt = counts[pos];
                  if (r.bump_count && cnt != 8'hFF) cnt = cnt + 8'd1;
                  drop_at(pos);
                  place(r.peer_key, r.backoff_time, cnt);
                  e.entry_count = cnt;
               end
            end
            default: ;
         endcase
         e.occupancy = 5'(fill);
         if (fill > 0) begin
            e.head_valid = 1'b1;
            e.head_key = keys[0];
            e.head_time = times[0];
            e.head_count = counts[0];
         end
         awaited.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected beat: status %0d occupancy %0d head %0b %h %h %h moved %h",
                        got.status, got.occupancy, got.head_valid, got.head_key,
                        got.head_time, got.head_count, got.entry_count);
            return;
         end
         e = awaited.pop_front();
         if (got.status !== e.status || got.occupancy !== e.occupancy ||
             got.head_valid !== e.head_valid || got.head_key !== e.head_key ||
             got.head_time !== e.head_time || got.head_count !== e.head_count ||
             got.entry_count !== e.entry_count) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch: expected status %0d occupancy %0d head %0b %h %h %h moved %h",
                        e.status, e.occupancy, e.head_valid, e.head_key,
                        e.head_time, e.head_count, e.entry_count);
               $display("          actual   status %0d occupancy %0d head %0b %h %h %h moved %h",
                        got.status, got.occupancy, got.head_valid, got.head_key,
                        got.head_time, got.head_count, got.entry_count);
            end
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   bit idle_enable = 1'b1;
   int unsigned cycle_count = 0;
   logic [63:0] key_pool[8];
   queue_mirror mirror = new;

   sorted_wait_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
   end

   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) mirror.check_response(rsp_data);
   end

   function automatic req_type build_req(logic [1:0] cmd, logic [63:0] key, logic [31:0] wt,
                                         logic [7:0] cnt, logic bump);
      req_type r;
      r.command = cmd;
      r.peer_key = key;
      r.backoff_time = wt;
      r.initial_count = cnt;
      r.bump_count = bump;
      return r;
   endfunction

   task automatic send_command(input req_type r);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      mirror.apply_command(r);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (mirror.awaited.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [1:0]  cmd;
      logic [63:0] key;
      logic [31:0] wt;
      logic [7:0]  cnt;
      bit filling;
      int roll;

      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < 8; i++) key_pool[i] = {$urandom, $urandom};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_command(build_req(CMD_UNUSED, key_pool[2], 32'd5, 8'd9, 1'b1));
      send_command(build_req(CMD_REMOVE, key_pool[2], 32'd0, 8'd0, 1'b0));
      send_command(build_req(CMD_MOVE, key_pool[3], 32'd100, 8'd0, 1'b1));
      send_command(build_req(CMD_INSERT, '1, 32'hFFFF_FFFF, 8'hFF, 1'b0));
      send_command(build_req(CMD_INSERT, '0, 32'd0, 8'd0, 1'b0));
      send_command(build_req(CMD_INSERT, key_pool[2], 32'd0, 8'd254, 1'b1));
      for (int i = 0; i < DEPTH - 3; i++)
         send_command(build_req(CMD_INSERT, {$urandom, $urandom}, $urandom_range(0, 15),
                                8'($urandom), 1'($urandom)));
      send_command(build_req(CMD_INSERT, key_pool[3], 32'd7, 8'd1, 1'b0));
      send_command(build_req(CMD_MOVE, '1, 32'd0, 8'd0, 1'b1));
      send_command(build_req(CMD_MOVE, '0, 32'hFFFF_FFFF, 8'd0, 1'b1));
      send_command(build_req(CMD_MOVE, key_pool[2], 32'd3, 8'd0, 1'b1));
      send_command(build_req(CMD_MOVE, key_pool[4], 32'd3, 8'd0, 1'b0));
      wait_for_drain();

      filling = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 150) idle_enable = 1'b0;
         if (n == 250 || n == 500) wait_for_drain();
         if (mirror.fill == 0) filling = 1'b1;
         else if (mirror.fill == DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
         else if ($urandom_range(0, 79) == 0) filling = !filling;

         roll = $urandom_range(0, 99);
         if (filling) cmd = roll < 50 ? CMD_INSERT : roll < 70 ? CMD_REMOVE : CMD_MOVE;
         else cmd = roll < 25 ? CMD_INSERT : roll < 65 ? CMD_REMOVE : CMD_MOVE;

         roll = $urandom_range(0, 99);
         if (cmd != CMD_INSERT && mirror.fill > 0 && roll < 85)
            key = mirror.keys[$urandom_range(0, mirror.fill - 1)];
         else if (roll < 92) key = key_pool[$urandom_range(0, 7)];
         else key = {$urandom, $urandom};

         roll = $urandom_range(0, 99);
         if (roll < 40) wt = $urandom_range(0, 15);
         else if (roll < 45) wt = '0;
         else if (roll < 50) wt = '1;
         else wt = $urandom;

         cnt = $urandom_range(0, 4) == 0 ? 8'($urandom_range(254, 255)) : 8'($urandom);
         send_command(build_req(cmd, key, wt, cnt, 1'($urandom)));
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.awaited.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/swq_pkg.sv
hw/rtl/swq_ctrl.sv
hw/rtl/swq_datapath.sv
hw/rtl/sorted_wait_queue.sv
bench/testbench.sv
